/* hw/rtl/irm_pkg.sv */
// ----------------------------------------------------------------------------
// irm_pkg
// Shared types and constants for the ICMP reply matcher.
// ----------------------------------------------------------------------------
package irm_pkg;

    localparam int unsigned POS_W  = 8;   // byte position, saturates at 255
    localparam int unsigned HDR_W  = 6;   // header length in bytes, up to 60
    localparam int unsigned CFG_W  = 16;  // widest configuration register
    localparam int unsigned CFG_IW = 1;   // configuration register index

    localparam logic [CFG_IW-1:0] CFG_EXPECTED_ID  = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_EXPECTED_SEQ = 1'b1;

    localparam logic [7:0] ECHO_REPLY_TYPE    = 8'd0;
    localparam logic [7:0] TIME_EXCEEDED_TYPE = 8'd11;

    // ICMP header size, and offsets of id/seq bytes inside an ICMP header
    localparam logic [POS_W-1:0] ICMP_HDR_BYTES = 8'd8;
    localparam logic [POS_W-1:0] OFF_ID_HI      = 8'd4;
    localparam logic [POS_W-1:0] OFF_ID_LO      = 8'd5;
    localparam logic [POS_W-1:0] OFF_SEQ_HI     = 8'd6;
    localparam logic [POS_W-1:0] OFF_SEQ_LO     = 8'd7;
    localparam logic [POS_W-1:0] POS_MAX        = 8'hFF;

    typedef enum logic [1:0] {
        KIND_OTHER         = 2'd0,
        KIND_ECHO_REPLY    = 2'd1,
        KIND_TIME_EXCEEDED = 2'd2
    } kind_t;

    typedef struct packed {
        logic       last_byte;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic  truncated;
        kind_t reply_kind;
        logic  matched;
    } verdict_t;

    // header length field scaled to bytes
    function automatic logic [HDR_W-1:0] ihl_bytes(input logic [7:0] b);
        return {b[3:0], 2'b00};
    endfunction

endpackage

/* hw/rtl/irm_in_reg.sv */
// ----------------------------------------------------------------------------
// irm_in_reg
// Input register stage: holds one request until the core consumes it.
// ----------------------------------------------------------------------------
module irm_in_reg
    import irm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     item_valid,
    output in_item_t item,
    input  logic     item_take
);

    logic     valid_reg, valid_next;
    in_item_t item_reg;

    // accept when empty or when the held request leaves this cycle
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hw/rtl/irm_core.sv */
// ----------------------------------------------------------------------------
// irm_core
// Per-packet parse state, id/seq compare and the verdict for the last byte.
// ----------------------------------------------------------------------------
module irm_core
    import irm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CFG_IW-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              fire,
    input  in_item_t          item,
    output verdict_t          verdict
);

    logic [CFG_W-1:0] exp_id_reg, exp_seq_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [HDR_W-1:0] outer_reg, outer_next, outer_upd;
    logic [HDR_W-1:0] inner_reg, inner_next, inner_upd;
    kind_t            kind_reg, kind_next, kind_upd;
    logic             id_ok_reg, id_ok_next, id_ok_upd;
    logic             seq_ok_reg, seq_ok_next, seq_ok_upd;
    logic             done_reg, done_next, done_upd;

    logic [7:0]       b;
    logic [POS_W-1:0] outer_ext, inner_ext, base, off;
    logic             in_fields, type_seen;
    kind_t            kind_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_id_reg  <= '0;
            exp_seq_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_EXPECTED_ID:  exp_id_reg  <= cfg_wr_data;
                CFG_EXPECTED_SEQ: exp_seq_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        b = item.data_byte;

        outer_upd = (pos_reg == '0) ? ihl_bytes(b) : outer_reg;
        outer_ext = {{(POS_W-HDR_W){1'b0}}, outer_upd};

        kind_upd = kind_reg;
        if (pos_reg == outer_ext) begin
            if (b == ECHO_REPLY_TYPE) begin
                kind_upd = KIND_ECHO_REPLY;
            end else if (b == TIME_EXCEEDED_TYPE) begin
                kind_upd = KIND_TIME_EXCEEDED;
            end else begin
                kind_upd = KIND_OTHER;
            end
        end

        // embedded IP header starts right after the outer ICMP header
        inner_upd = inner_reg;
        if (kind_upd == KIND_TIME_EXCEEDED && pos_reg == outer_ext + ICMP_HDR_BYTES) begin
            inner_upd = ihl_bytes(b);
        end
        inner_ext = {{(POS_W-HDR_W){1'b0}}, inner_upd};

        base = (kind_upd == KIND_ECHO_REPLY) ? outer_ext
                                             : outer_ext + ICMP_HDR_BYTES + inner_ext;
        off       = pos_reg - base;
        in_fields = (kind_upd != KIND_OTHER) && (pos_reg >= base);

        id_ok_upd  = id_ok_reg;
        seq_ok_upd = seq_ok_reg;
        done_upd   = done_reg;
        if (in_fields) begin
            if (off == OFF_ID_HI  && b != exp_id_reg[15:8])  id_ok_upd  = 1'b0;
            if (off == OFF_ID_LO  && b != exp_id_reg[7:0])   id_ok_upd  = 1'b0;
            if (off == OFF_SEQ_HI && b != exp_seq_reg[15:8]) seq_ok_upd = 1'b0;
            if (off == OFF_SEQ_LO) begin
                if (b != exp_seq_reg[7:0]) seq_ok_upd = 1'b0;
                done_upd = 1'b1;
            end
        end

        type_seen = pos_reg >= outer_ext;
        kind_out  = type_seen ? kind_upd : KIND_OTHER;

        verdict.reply_kind = kind_out;
        verdict.truncated  = !type_seen || (kind_out != KIND_OTHER && !done_upd);
        verdict.matched    = (kind_out != KIND_OTHER) && done_upd && id_ok_upd && seq_ok_upd;

        // hold when idle, drop back to packet start after the last byte
        pos_next    = pos_reg;
        outer_next  = outer_reg;
        inner_next  = inner_reg;
        kind_next   = kind_reg;
        id_ok_next  = id_ok_reg;
        seq_ok_next = seq_ok_reg;
        done_next   = done_reg;
        if (fire) begin
            if (item.last_byte) begin
                pos_next    = '0;
                outer_next  = '0;
                inner_next  = '0;
                kind_next   = KIND_OTHER;
                id_ok_next  = 1'b1;
                seq_ok_next = 1'b1;
                done_next   = 1'b0;
            end else begin
                pos_next    = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : pos_reg;
                outer_next  = outer_upd;
                inner_next  = inner_upd;
                kind_next   = kind_upd;
                id_ok_next  = id_ok_upd;
                seq_ok_next = seq_ok_upd;
                done_next   = done_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            outer_reg  <= '0;
            inner_reg  <= '0;
            kind_reg   <= KIND_OTHER;
            id_ok_reg  <= 1'b1;
            seq_ok_reg <= 1'b1;
            done_reg   <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            outer_reg  <= outer_next;
            inner_reg  <= inner_next;
            kind_reg   <= kind_next;
            id_ok_reg  <= id_ok_next;
            seq_ok_reg <= seq_ok_next;
            done_reg   <= done_next;
        end
    end

endmodule

/* hw/rtl/irm_out_reg.sv */
// ----------------------------------------------------------------------------
// irm_out_reg
// Result register: holds a verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module irm_out_reg
    import irm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  verdict_t verdict_in,
    output logic     free,
    output logic     out_valid,
    input  logic     out_ready,
    output verdict_t verdict_out
);

    logic     valid_reg, valid_next;
    verdict_t verdict_reg;

    assign free = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (out_ready) valid_next = 1'b0;
        if (load)      valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            verdict_reg <= verdict_in;
        end
    end

    assign out_valid   = valid_reg;
    assign verdict_out = verdict_reg;

endmodule

/* hw/rtl/icmp_reply_matcher.sv */
// A last byte passes the input register, then the result register, before its verdict shows on m_*.
// Throughput: one byte per cycle while no last byte waits; the parse state is updated once per byte.
// A last byte waits in the input register only while the result register is full.
// Reset: synchronous, active-low aresetn clears the parse state, both registers
// (expected id/seq to zero) and all valid flags.
// ----------------------------------------------------------------------------
// icmp_reply_matcher
// Byte-stream matcher for ICMP echo reply and time exceeded replies to a probe.
// ----------------------------------------------------------------------------
module icmp_reply_matcher
    import irm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    // configuration: index 0 expected_id, index 1 expected_seq
    input  logic              cfg_wr_en,
    input  logic [CFG_IW-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]  cfg_wr_data,

    // packet bytes, starting at the outer IP header
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tlast,   // last_byte

    // one verdict per packet
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [0] matched, [1] truncated, [7:2] zero
    output logic [1:0]        m_tuser    // [1:0] reply_kind
);

    in_item_t s_item, item;
    logic     item_valid, item_take, fire, out_free, load;
    verdict_t verdict, verdict_q;

    assign s_item.data_byte = s_tdata;
    assign s_item.last_byte = s_tlast;

    // input register parts the upstream handshake from the parse logic
    irm_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // a non-last byte never needs the result slot; a last byte advances
    // only when the result register is empty or being drained
    assign item_take = item_valid && (!item.last_byte || out_free);
    assign fire      = item_take;
    assign load      = fire && item.last_byte;

    irm_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .fire         (fire),
        .item         (item),
        .verdict      (verdict)
    );

    // result register: hold the verdict until m_tready
    irm_out_reg u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .verdict_in  (verdict),
        .free        (out_free),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .verdict_out (verdict_q)
    );

    assign m_tdata = {6'b000000, verdict_q.truncated, verdict_q.matched};
    assign m_tuser = verdict_q.reply_kind;

endmodule

/* hw/rtl/irm_checker.sv */
// ----------------------------------------------------------------------------
// irm_checker
// Port-level checks for the ICMP reply matcher, bound to the top level.
// ----------------------------------------------------------------------------
module irm_checker
    import irm_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    // no verdict right after a reset cycle
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("verdict valid after reset");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_OTHER || m_tuser == KIND_ECHO_REPLY ||
                      m_tuser == KIND_TIME_EXCEEDED))
        else $error("illegal reply kind");

    // a match needs a known kind and complete id/seq fields
    a_match_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (!m_tdata[1] && m_tuser != KIND_OTHER))
        else $error("match with truncated packet or other kind");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:2] == 6'b000000))
        else $error("nonzero pad bits in verdict");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("verdict changed while stalled");

endmodule

bind icmp_reply_matcher irm_checker u_irm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
